// File: design/cst_pkg.sv
package cst_pkg;

  localparam int MAX_ROWS     = 65535;
  localparam int MAX_COLUMNS  = 255;
  localparam int MAX_COMMENTS = 4095;
  localparam int MAX_LINE_LEN = 4095;

  localparam logic [15:0] ROW_LIM = 16'(MAX_ROWS < 65535 ? MAX_ROWS : 65535);
  localparam logic [7:0]  COL_LIM = 8'(MAX_COLUMNS < 255 ? MAX_COLUMNS : 255);
  localparam logic [11:0] CMT_LIM = 12'(MAX_COMMENTS < 4095 ? MAX_COMMENTS : 4095);
  localparam logic [11:0] LEN_LIM = 12'(MAX_LINE_LEN < 4095 ? MAX_LINE_LEN : 4095);

  localparam logic [7:0] CHAR_CR        = 8'd13;
  localparam logic [7:0] CHAR_LF        = 8'd10;
  localparam logic [7:0] SEPARATOR_INIT = 8'd59;
  localparam logic [7:0] COMMENT_INIT   = 8'd35;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int ADDR_W = 3;

  typedef enum logic [2:0] {
    EV_CELL_BYTE = 3'd0,
    EV_CELL_END  = 3'd1,
    EV_CMT_BYTE  = 3'd2,
    EV_CMT_END   = 3'd3,
    EV_ROW_END   = 3'd4
  } evt_kind_t;

  typedef struct packed {
    evt_kind_t   event_kind;
    logic [7:0]  byte_value;
    logic [15:0] row_index;
    logic [7:0]  column_index;
    logic [11:0] comment_number;
    logic [11:0] item_length;
    logic        last_of_run;
  } evt_t;

  typedef struct packed {
    logic [1:0]     count;
    evt_t [2:0]     ev;
  } bundle_t;

  typedef struct packed {
    logic push;
    logic full;
  } qctl_t;

  function automatic logic [7:0] sat8(input logic [7:0] v, input logic [7:0] lim);
    return (v < lim) ? v + 8'd1 : lim;
  endfunction

  function automatic logic [11:0] sat12(input logic [11:0] v, input logic [11:0] lim);
    return (v < lim) ? v + 12'd1 : lim;
  endfunction

  function automatic logic [15:0] sat16(input logic [15:0] v, input logic [15:0] lim);
    return (v < lim) ? v + 16'd1 : lim;
  endfunction

  function automatic evt_t make_evt(input evt_kind_t k, input logic [7:0] b,
                                    input logic [15:0] r, input logic [7:0] c,
                                    input logic [11:0] m, input logic [11:0] len);
    evt_t e;
    e.event_kind     = k;
    e.byte_value     = b;
    e.row_index      = r;
    e.column_index   = c;
    e.comment_number = m;
    e.item_length    = len;
    e.last_of_run    = 1'b0;
    return e;
  endfunction

endpackage

// File: design/cst_ifs.sv
interface cst_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source(output valid, output data_byte, output final_byte, input ready);
  modport sink(input valid, input data_byte, input final_byte, output ready);
endinterface

interface cst_event_if;
  logic                valid;
  logic                ready;
  cst_pkg::evt_kind_t  event_kind;
  logic [7:0]          byte_value;
  logic [15:0]         row_index;
  logic [7:0]          column_index;
  logic [11:0]         comment_number;
  logic [11:0]         item_length;
  logic                last_of_run;

  modport source(output valid, output event_kind, output byte_value, output row_index,
                 output column_index, output comment_number, output item_length,
                 output last_of_run, input ready);
  modport sink(input valid, input event_kind, input byte_value, input row_index,
               input column_index, input comment_number, input item_length,
               input last_of_run, output ready);
endinterface

// File: design/csv_stream_tokenizer.sv
// An accepted byte's events enter the queue first, then the output register.
// Throughput: one byte per cycle unless the queue is full; a line end with up to three
// events has them drained singly from a four-bundle queue by the output register.
// Reset: synchronous rst clears all counters, the queue and the output valid, and
// returns separator_char to ';' and comment_char to '#'.
module csv_stream_tokenizer (
  input  logic                        clk,
  input  logic                        rst,
  cst_byte_if.sink                    bytes,
  cst_event_if.source                 events,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cst_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [7:0]        separator_char;
  logic [7:0]        comment_char;
  logic              cfg_write;
  cst_pkg::qctl_t    qctl;
  cst_pkg::bundle_t  bundle;
  cst_pkg::bundle_t  head;
  logic              queue_full;
  logic              head_valid;
  logic              pop;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = paddr[2] ? {24'd0, comment_char} : {24'd0, separator_char};

  always_ff @(posedge clk) begin
    if (rst) begin
      separator_char <= cst_pkg::SEPARATOR_INIT;
      comment_char   <= cst_pkg::COMMENT_INIT;
    end else if (cfg_write) begin
      if (paddr[2]) begin
        comment_char <= pwdata[7:0];
      end else begin
        separator_char <= pwdata[7:0];
      end
    end
  end

  cst_front u_front (
    .clk            (clk),
    .rst            (rst),
    .bytes          (bytes),
    .separator_char (separator_char),
    .comment_char   (comment_char),
    .queue_full     (queue_full),
    .qctl           (qctl),
    .bundle         (bundle)
  );

  cst_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr_bundle  (bundle),
    .push       (qctl.push),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  cst_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .events     (events)
  );

endmodule

// File: design/cst_front.sv
module cst_front (
  input  logic              clk,
  input  logic              rst,
  cst_byte_if.sink          bytes,
  input  logic [7:0]        separator_char,
  input  logic [7:0]        comment_char,
  input  logic              queue_full,
  output cst_pkg::qctl_t    qctl,
  output cst_pkg::bundle_t  bundle
);

  logic        in_comment, in_comment_next;
  logic [11:0] cell_count, cell_count_next;
  logic [11:0] comment_count, comment_count_next;
  logic [15:0] row_counter, row_counter_next;
  logic [7:0]  column_counter, column_counter_next;
  logic [11:0] comment_counter, comment_counter_next;

  logic        accept;
  logic        eol;
  logic [1:0]  n;
  logic [7:0]  col_a;
  logic [11:0] cmn_a;
  logic [7:0]  c;

  assign c            = bytes.data_byte;
  assign bytes.ready  = !queue_full;
  assign accept       = bytes.valid && bytes.ready;
  assign eol          = (c == cst_pkg::CHAR_CR) || (c == cst_pkg::CHAR_LF);
  assign qctl.full    = queue_full;
  assign qctl.push    = accept && (n != 2'd0);

  always_comb begin
    in_comment_next      = in_comment;
    cell_count_next      = cell_count;
    comment_count_next   = comment_count;
    row_counter_next     = row_counter;
    column_counter_next  = column_counter;
    comment_counter_next = comment_counter;
    col_a                = column_counter;
    cmn_a                = comment_counter;
    n                    = 2'd0;
    bundle               = '0;
    if (eol) begin
      if (in_comment) begin
        bundle.ev[n] = cst_pkg::make_evt(cst_pkg::EV_CMT_END, 8'd0, row_counter,
                                         column_counter, comment_counter, comment_count);
        n = n + 2'd1;
        cmn_a = cst_pkg::sat12(comment_counter, cst_pkg::CMT_LIM);
      end
      if (cell_count != 12'd0) begin
        bundle.ev[n] = cst_pkg::make_evt(cst_pkg::EV_CELL_END, 8'd0, row_counter,
                                         column_counter, cmn_a, cell_count);
        n = n + 2'd1;
        col_a = cst_pkg::sat8(column_counter, cst_pkg::COL_LIM);
      end
      if (col_a != 8'd0) begin
        bundle.ev[n] = cst_pkg::make_evt(cst_pkg::EV_ROW_END, 8'd0, row_counter,
                                         col_a, cmn_a, 12'd0);
        n = n + 2'd1;
        row_counter_next = cst_pkg::sat16(row_counter, cst_pkg::ROW_LIM);
      end
      in_comment_next      = 1'b0;
      cell_count_next      = 12'd0;
      comment_count_next   = 12'd0;
      column_counter_next  = 8'd0;
      comment_counter_next = cmn_a;
    end else if (in_comment) begin
      bundle.ev[n] = cst_pkg::make_evt(cst_pkg::EV_CMT_BYTE, c, row_counter,
                                       column_counter, comment_counter, 12'd0);
      n = n + 2'd1;
      comment_count_next = cst_pkg::sat12(comment_count, cst_pkg::LEN_LIM);
    end else if (c == comment_char) begin
      in_comment_next    = 1'b1;
      comment_count_next = 12'd0;
    end else if (c == separator_char) begin
      if (cell_count != 12'd0) begin
        bundle.ev[n] = cst_pkg::make_evt(cst_pkg::EV_CELL_END, 8'd0, row_counter,
                                         column_counter, comment_counter, cell_count);
        n = n + 2'd1;
        cell_count_next = 12'd0;
      end
      column_counter_next = cst_pkg::sat8(column_counter, cst_pkg::COL_LIM);
    end else begin
      bundle.ev[n] = cst_pkg::make_evt(cst_pkg::EV_CELL_BYTE, c, row_counter,
                                       column_counter, comment_counter, 12'd0);
      n = n + 2'd1;
      cell_count_next = cst_pkg::sat12(cell_count, cst_pkg::LEN_LIM);
    end
    if (n != 2'd0) begin
      bundle.ev[n - 2'd1].last_of_run = 1'b1;
    end
    bundle.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && bytes.final_byte)) begin
      in_comment      <= 1'b0;
      cell_count      <= '0;
      comment_count   <= '0;
      row_counter     <= '0;
      column_counter  <= '0;
      comment_counter <= '0;
    end else if (accept) begin
      in_comment      <= in_comment_next;
      cell_count      <= cell_count_next;
      comment_count   <= comment_count_next;
      row_counter     <= row_counter_next;
      column_counter  <= column_counter_next;
      comment_counter <= comment_counter_next;
    end
  end

  a_cmt_len_zero_outside: assert property (@(posedge clk) disable iff (rst)
    !in_comment |-> comment_count == 12'd0)
    else $error("comment length nonzero outside a comment");

  a_row_sat: assert property (@(posedge clk) disable iff (rst)
    row_counter <= cst_pkg::ROW_LIM)
    else $error("row counter beyond its limit");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    qctl.push |-> !queue_full)
    else $error("push while queue full");

endmodule

// File: design/cst_queue.sv
module cst_queue (
  input  logic              clk,
  input  logic              rst,
  input  cst_pkg::bundle_t  wr_bundle,
  input  logic              push,
  input  logic              pop,
  output logic              full,
  output logic              head_valid,
  output cst_pkg::bundle_t  head
);

  cst_pkg::bundle_t mem [cst_pkg::QUEUE_DEPTH];
  logic [cst_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [cst_pkg::QCNT_W-1:0] count;

  assign full       = (count == cst_pkg::QCNT_W'(cst_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + cst_pkg::QCNT_W'(push) - cst_pkg::QCNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !head_valid))
    else $error("pop from empty queue");

  a_no_empty_bundle: assert property (@(posedge clk) disable iff (rst)
    push |-> wr_bundle.count != 2'd0)
    else $error("bundle without events queued");

endmodule

// File: design/cst_back.sv
module cst_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  cst_pkg::bundle_t  head,
  output logic              pop,
  cst_event_if.source       events
);

  logic         out_valid;
  cst_pkg::evt_t out_evt;
  logic [1:0]   slot;
  logic         load;
  logic         last_slot;

  assign load      = head_valid && (!out_valid || events.ready);
  assign last_slot = (slot == head.count - 2'd1);
  assign pop       = load && last_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      slot      <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        slot      <= last_slot ? 2'd0 : slot + 2'd1;
      end else if (events.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_evt <= head.ev[slot];
    end
  end

  assign events.valid          = out_valid;
  assign events.event_kind     = out_evt.event_kind;
  assign events.byte_value     = out_evt.byte_value;
  assign events.row_index      = out_evt.row_index;
  assign events.column_index   = out_evt.column_index;
  assign events.comment_number = out_evt.comment_number;
  assign events.item_length    = out_evt.item_length;
  assign events.last_of_run    = out_evt.last_of_run;

  a_slot_in_bundle: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> slot < head.count)
    else $error("slot beyond bundle");

  a_pop_ends_run: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_evt.last_of_run)
    else $error("bundle retired without its last event");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !events.ready |=> out_valid && $stable(out_evt))
    else $error("output changed while stalled");

endmodule
